[hdl/trapezoidal_profile_sampler_core_macros.svh]
// Assertion macros shared by the trapezoidal profile sampler RTL.
// Each module that uses them has ports named clk and rst.
`ifndef TRAPEZOIDAL_PROFILE_SAMPLER_CORE_MACROS_SVH
`define TRAPEZOIDAL_PROFILE_SAMPLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tps assertion failed");
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tps assertion failed");
`else
`define TPS_ASSERT_IMP(lbl, ante, cons)
`define TPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/tps_pkg.sv]
// Shared constants, codes and types of the trapezoidal profile sampler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package tps_pkg;
  localparam int TFB = 16;
  localparam int LEN_W = 31;
  localparam int PROD_W = 64;
  localparam int QW = PROD_W - LEN_W;
  localparam int LIN_W = 63 - TFB;
  localparam int RAMP_SH = 2 * TFB + 1;
  localparam int RAMP_W = 95 - RAMP_SH;

  localparam logic [1:0] REG_PLEN = 2'd0;
  localparam logic [1:0] REG_VLIM = 2'd1;
  localparam logic [1:0] REG_ALIM = 2'd2;

  typedef enum logic [1:0] {PH_ACCEL, PH_CRUISE, PH_DECEL, PH_DEGEN} tps_phase_t;

  typedef struct packed {
    logic [31:0]        acc;
    logic [31:0]        cru;
    logic [31:0]        total;
    logic [32:0]        cend;
    logic [LEN_W-1:0]   peak;
    logic [LEN_W-1:0]   aa;
    logic [LEN_W-1:0]   plen;
    logic [RAMP_W-1:0]  ramp_acc;
    logic [LIN_W-1:0]   cdist;
    logic               deg;
  } tps_prof_t;

  typedef struct packed {
    logic               done;
    tps_phase_t         phase;
    logic               neg;
    logic [32:0]        mag;
    logic [31:0]        a_start;
    logic [31:0]        a_end;
    logic [LEN_W-1:0]   pos;
    logic [LEN_W-1:0]   spd;
  } tps_side_t;
endpackage

[hdl/tps_derive.sv]
// Configuration registers and the sequencer that derives the move timing.
// Uses tps_pkg; shares one serial divider and one serial square root.
`timescale 1ns / 1ps
`include "trapezoidal_profile_sampler_core_macros.svh"
module tps_derive (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  output logic                busy,
  output tps_pkg::tps_prof_t  prof
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CLASS, S_DIV, S_SQRT, S_TOTAL, S_RAMP1, S_RAMP2, S_RAMP3
  } state_t;
  typedef enum logic [2:0] {DK_CONST, DK_FULL, DK_ACC_V, DK_CRU, DK_ACC_PK} kind_t;

  localparam logic [5:0] DIV_LAST = 6'd63;
  localparam logic [5:0] SQRT_LAST = 6'd31;

  state_t state;
  kind_t kind;
  logic [5:0] cnt;
  logic [30:0] plen, vlim, alim;
  logic [63:0] dvd;
  logic [30:0] dvs, rem, full;
  logic [63:0] sq_x, sq_r, sq_bit;
  logic [61:0] vv, pa;
  logic [31:0] acc, cru, total;
  logic [32:0] cend;
  logic [30:0] peak, aa;
  logic [62:0] m_ra, r1;
  logic [63:0] r0;
  logic [tps_pkg::LIN_W-1:0] cd;
  logic [tps_pkg::RAMP_W-1:0] ramp_acc;

  logic [31:0] div_t;
  logic div_ge;
  logic [31:0] div_rem;
  logic [63:0] div_q;
  logic [63:0] sq_sum, sq_r_next;
  logic sq_ge;
  logic [62:0] pa1;
  logic trap, wr_ok;
  logic [62:0] cd_prod;
  logic [62:0] cd_full;
  logic [94:0] ramp_sum, ramp_full;

  function automatic logic [31:0] sat32(input logic [63:0] q);
    return (|q[63:32]) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  always_comb begin
    div_t = {rem, dvd[63]};
    div_ge = div_t >= {1'b0, dvs};
    div_rem = div_ge ? (div_t - {1'b0, dvs}) : div_t;
    div_q = {dvd[62:0], div_ge};
    sq_sum = sq_r + sq_bit;
    sq_ge = sq_x >= sq_sum;
    sq_r_next = sq_ge ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);
    pa1 = {1'b0, pa} + {32'b0, alim};
    trap = {1'b0, vv} < pa1;
    wr_ok = cfg_we && (cfg_index == tps_pkg::REG_PLEN || cfg_index == tps_pkg::REG_VLIM ||
                       cfg_index == tps_pkg::REG_ALIM);
    cd_prod = 63'(peak) * 63'(cru);
    cd_full = cd_prod >> tps_pkg::TFB;
    ramp_sum = {r1, 32'b0} + {31'b0, r0};
    ramp_full = ramp_sum >> tps_pkg::RAMP_SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      plen <= '0;
      vlim <= '0;
      alim <= '0;
      acc <= '0;
      cru <= '0;
      total <= '0;
      cend <= '0;
      peak <= '0;
      aa <= '0;
      cd <= '0;
      ramp_acc <= '0;
    end else if (wr_ok) begin
      unique case (cfg_index)
        tps_pkg::REG_PLEN: plen <= cfg_data;
        tps_pkg::REG_VLIM: vlim <= cfg_data;
        default:           alim <= cfg_data;
      endcase
      state <= S_MUL;
    end else begin
      unique case (state)
        S_IDLE: begin
        end
        S_MUL: begin
          vv <= 62'(vlim) * 62'(vlim);
          pa <= 62'(plen) * 62'(alim);
          state <= S_CLASS;
        end
        S_CLASS: begin
          acc <= '0;
          cru <= '0;
          peak <= '0;
          aa <= '0;
          cnt <= '0;
          rem <= '0;
          if (plen == '0 || vlim == '0) begin
            state <= S_TOTAL;
          end else if (alim == '0) begin
            dvd <= 64'(plen) << tps_pkg::TFB;
            dvs <= vlim;
            kind <= DK_CONST;
            state <= S_DIV;
          end else if (trap) begin
            dvd <= {2'b0, vv};
            dvs <= alim;
            kind <= DK_FULL;
            state <= S_DIV;
          end else begin
            sq_x <= {2'b0, pa};
            sq_r <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            state <= S_SQRT;
          end
        end
        S_DIV: begin
          dvd <= div_q;
          rem <= div_rem[30:0];
          cnt <= cnt + 6'd1;
          if (cnt == DIV_LAST) begin
            rem <= '0;
            unique case (kind)
              DK_CONST: begin
                cru <= sat32(div_q);
                peak <= vlim;
                state <= S_TOTAL;
              end
              DK_FULL: begin
                full <= div_q[30:0];
                dvd <= 64'(vlim) << tps_pkg::TFB;
                dvs <= alim;
                kind <= DK_ACC_V;
              end
              DK_ACC_V: begin
                acc <= sat32(div_q);
                peak <= vlim;
                dvd <= 64'(plen - full) << tps_pkg::TFB;
                dvs <= vlim;
                kind <= DK_CRU;
              end
              DK_CRU: begin
                cru <= sat32(div_q);
                aa <= alim;
                state <= S_TOTAL;
              end
              default: begin
                acc <= sat32(div_q);
                aa <= alim;
                state <= S_TOTAL;
              end
            endcase
          end
        end
        S_SQRT: begin
          if (sq_ge) sq_x <= sq_x - sq_sum;
          sq_r <= sq_r_next;
          sq_bit <= sq_bit >> 2;
          cnt <= cnt + 6'd1;
          if (cnt == SQRT_LAST) begin
            peak <= sq_r_next[30:0];
            dvd <= sq_r_next << tps_pkg::TFB;
            dvs <= alim;
            rem <= '0;
            cnt <= '0;
            kind <= DK_ACC_PK;
            state <= S_DIV;
          end
        end
        S_TOTAL: begin
          total <= sat32(({32'b0, acc} << 1) + {32'b0, cru});
          cend <= {1'b0, acc} + {1'b0, cru};
          state <= S_RAMP1;
        end
        S_RAMP1: begin
          m_ra <= 63'(aa) * 63'(acc);
          state <= S_RAMP2;
        end
        S_RAMP2: begin
          r1 <= 63'(m_ra[62:32]) * 63'(acc);
          r0 <= 64'(m_ra[31:0]) * 64'(acc);
          cd <= cd_full[tps_pkg::LIN_W-1:0];
          state <= S_RAMP3;
        end
        default: begin
          ramp_acc <= ramp_full[tps_pkg::RAMP_W-1:0];
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    busy = state != S_IDLE;
    prof.acc = acc;
    prof.cru = cru;
    prof.total = total;
    prof.cend = cend;
    prof.peak = peak;
    prof.aa = aa;
    prof.plen = plen;
    prof.ramp_acc = ramp_acc;
    prof.cdist = cd;
    prof.deg = total == '0;
  end

  `TPS_ASSERT_NEXT(a_write_starts_derive, wr_ok, busy)
endmodule

[hdl/tps_front.sv]
// Profile pipeline: clamps the time, picks the phase, forms path speed and
// position, and multiplies them by the axis span. Uses tps_pkg.
`timescale 1ns / 1ps
`include "trapezoidal_profile_sampler_core_macros.svh"
module tps_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [31:0]         sample_time,
  input  logic [31:0]         axis_start,
  input  logic [31:0]         axis_end,
  input  tps_pkg::tps_prof_t  prof,
  output logic                out_valid,
  output logic [63:0]         nx,
  output logic [63:0]         ny,
  output tps_pkg::tps_side_t  side
);
  logic v_a, v_b, v_c, v_d, v_e, v_f, v_g;
  tps_pkg::tps_side_t s_a, s_b, s_c, s_d, s_e, s_f, s_g;
  logic [31:0] t_a, u_b, u_c;
  logic [62:0] m1_c, m2_c, r1_d;
  logic [63:0] r0_d, base_e, posw_f;
  logic [tps_pkg::LIN_W-1:0] lin_d;
  logic [tps_pkg::RAMP_W-1:0] ramp_e;

  logic [32:0] diff, mag;
  logic [31:0] tc, u;
  logic [32:0] td;
  logic le_acc, le_cend;
  tps_pkg::tps_phase_t ph;
  logic [62:0] drop, lin_full;
  logic [30:0] spd;
  logic [94:0] ramp_sum, ramp_full;
  logic [63:0] base;

  always_comb begin
    diff = {axis_end[31], axis_end} - {axis_start[31], axis_start};
    mag = diff[32] ? (~diff + 33'd1) : diff;
    tc = s_a.done ? prof.total : t_a;
    le_acc = tc <= prof.acc;
    le_cend = {1'b0, tc} <= prof.cend;
    td = {1'b0, tc} - prof.cend;
    if (le_acc) begin
      ph = tps_pkg::PH_ACCEL;
      u = tc;
    end else if (le_cend) begin
      ph = tps_pkg::PH_CRUISE;
      u = tc - prof.acc;
    end else begin
      ph = tps_pkg::PH_DECEL;
      u = td[31:0];
    end
    drop = m1_c >> tps_pkg::TFB;
    lin_full = m2_c >> tps_pkg::TFB;
    case (s_c.phase)
      tps_pkg::PH_ACCEL:  spd = drop[30:0];
      tps_pkg::PH_CRUISE: spd = prof.peak;
      default:            spd = (drop >= 63'(prof.peak)) ? '0 : (prof.peak - drop[30:0]);
    endcase
    ramp_sum = {r1_d, 32'b0} + {31'b0, r0_d};
    ramp_full = ramp_sum >> tps_pkg::RAMP_SH;
    if (s_d.phase == tps_pkg::PH_CRUISE) begin
      base = 64'(prof.ramp_acc) + 64'(lin_d);
    end else begin
      base = 64'(prof.ramp_acc) + 64'(prof.cdist) + 64'(lin_d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
      v_f <= 1'b0;
      v_g <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
      v_e <= v_d;
      v_f <= v_e;
      v_g <= v_f;
      out_valid <= v_g;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_a <= sample_time;
      s_a.done <= sample_time >= prof.total;
      s_a.phase <= tps_pkg::PH_ACCEL;
      s_a.neg <= diff[32];
      s_a.mag <= mag;
      s_a.a_start <= axis_start;
      s_a.a_end <= axis_end;
      s_a.pos <= '0;
      s_a.spd <= '0;

      s_b <= s_a;
      s_b.phase <= ph;
      u_b <= u;

      s_c <= s_b;
      u_c <= u_b;
      m1_c <= 63'(prof.aa) * 63'(u_b);
      m2_c <= 63'(prof.peak) * 63'(u_b);

      s_d <= s_c;
      s_d.spd <= spd;
      r1_d <= 63'(m1_c[62:32]) * 63'(u_c);
      r0_d <= 64'(m1_c[31:0]) * 64'(u_c);
      lin_d <= lin_full[tps_pkg::LIN_W-1:0];

      s_e <= s_d;
      ramp_e <= ramp_full[tps_pkg::RAMP_W-1:0];
      base_e <= base;

      s_f <= s_e;
      case (s_e.phase)
        tps_pkg::PH_ACCEL:  posw_f <= 64'(ramp_e);
        tps_pkg::PH_CRUISE: posw_f <= base_e;
        default:            posw_f <= (64'(ramp_e) >= base_e) ? '0 : (base_e - 64'(ramp_e));
      endcase

      s_g <= s_f;
      s_g.pos <= (s_f.done || posw_f > 64'(prof.plen)) ? prof.plen : posw_f[30:0];

      side <= s_g;
      nx <= 64'(s_g.mag) * 64'(s_g.pos);
      ny <= 64'(s_g.mag) * 64'(s_g.spd);
    end
  end

  `TPS_ASSERT_NEXT(a_front_valid_moves, adv, out_valid == $past(v_g))
endmodule

[hdl/tps_div.sv]
// Pipelined restoring divider: two quotients by the path length, one bit
// per stage, with the item's side data carried alongside. Uses tps_pkg.
`timescale 1ns / 1ps
`include "trapezoidal_profile_sampler_core_macros.svh"
module tps_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [63:0]               nx,
  input  logic [63:0]               ny,
  input  tps_pkg::tps_side_t        in_side,
  input  logic [tps_pkg::LEN_W-1:0] plen,
  output logic                      out_valid,
  output logic [tps_pkg::QW-1:0]    qx,
  output logic [tps_pkg::QW-1:0]    qy,
  output logic                      ovy,
  output tps_pkg::tps_side_t        out_side
);
  localparam int QW = tps_pkg::QW;
  localparam int LW = tps_pkg::LEN_W;

  logic               v_s  [0:QW];
  logic [LW-1:0]      rx_s [0:QW];
  logic [LW-1:0]      ry_s [0:QW];
  logic [QW-1:0]      qx_s [0:QW];
  logic [QW-1:0]      qy_s [0:QW];
  logic               ov_s [0:QW];
  tps_pkg::tps_side_t sd_s [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (adv) begin
      v_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_s[0] <= nx[63:QW];
      qx_s[0] <= nx[QW-1:0];
      ry_s[0] <= ny[63:QW];
      qy_s[0] <= ny[QW-1:0];
      ov_s[0] <= ny[63:QW] >= plen;
      sd_s[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [LW:0] tx, ty, dx, dy;
    logic gx, gy;
    always_comb begin
      tx = {rx_s[k], qx_s[k][QW-1]};
      ty = {ry_s[k], qy_s[k][QW-1]};
      gx = tx >= {1'b0, plen};
      gy = ty >= {1'b0, plen};
      dx = gx ? (tx - {1'b0, plen}) : tx;
      dy = gy ? (ty - {1'b0, plen}) : ty;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (adv) begin
        v_s[k+1] <= v_s[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rx_s[k+1] <= dx[LW-1:0];
        ry_s[k+1] <= dy[LW-1:0];
        qx_s[k+1] <= {qx_s[k][QW-2:0], gx};
        qy_s[k+1] <= {qy_s[k][QW-2:0], gy};
        ov_s[k+1] <= ov_s[k];
        sd_s[k+1] <= sd_s[k];
      end
    end
  end

  assign out_valid = v_s[QW];
  assign qx = qx_s[QW];
  assign qy = qy_s[QW];
  assign ovy = ov_s[QW];
  assign out_side = sd_s[QW];

  `TPS_ASSERT_NEXT(a_div_valid_moves, adv, v_s[QW] == $past(v_s[QW-1]))
endmodule

[hdl/trapezoidal_profile_sampler_core.sv]
// Trapezoidal profile sampler: takes one sample item per clock while s_tready
// is high and returns one result item per sample. Throughput is one item per
// cycle when no stall holds it, set by the fully pipelined multipliers and the
// one-bit-per-stage divider by the path length. Each register write starts the
// timing derivation, a serial divider and square root that keeps s_tready low
// while it runs. Depends on tps_pkg, tps_derive, tps_front, tps_div.
`timescale 1ns / 1ps
`include "trapezoidal_profile_sampler_core_macros.svh"
module trapezoidal_profile_sampler_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // sample_time[31:0], axis_start[63:32], axis_end[95:64]
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // path_position[30:0], path_speed[61:31], axis_position[93:62],
  // axis_velocity[125:94], phase[127:126], move_done[128], zero fill above
  output logic [135:0] m_tdata
);
  logic busy, adv, f_valid, d_valid, ovy;
  tps_pkg::tps_prof_t prof;
  tps_pkg::tps_side_t f_side, d_side;
  logic [63:0] nx, ny;
  logic [tps_pkg::QW-1:0] qx, qy;

  logic [30:0] pos_o, spd_o;
  logic [31:0] axp_o, vel_o;
  tps_pkg::tps_phase_t phase_o;
  logic done_o;

  logic [33:0] ax_sum;
  logic [31:0] ax_sat, av, vel;

  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv && !busy;

  tps_derive u_derive (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .busy(busy), .prof(prof)
  );

  tps_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s_tvalid && s_tready),
    .sample_time(s_tdata[31:0]), .axis_start(s_tdata[63:32]),
    .axis_end(s_tdata[95:64]), .prof(prof), .out_valid(f_valid),
    .nx(nx), .ny(ny), .side(f_side)
  );

  tps_div u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(f_valid), .nx(nx), .ny(ny),
    .in_side(f_side), .plen(prof.plen), .out_valid(d_valid), .qx(qx),
    .qy(qy), .ovy(ovy), .out_side(d_side)
  );

  always_comb begin
    if (d_side.neg) begin
      ax_sum = {{2{d_side.a_start[31]}}, d_side.a_start} - {1'b0, qx};
    end else begin
      ax_sum = {{2{d_side.a_start[31]}}, d_side.a_start} + {1'b0, qx};
    end
    if (ax_sum[33:31] == 3'b000 || ax_sum[33:31] == 3'b111) begin
      ax_sat = ax_sum[31:0];
    end else begin
      ax_sat = ax_sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    av = (ovy || qy > 33'h0_8000_0000) ? 32'h8000_0000 : qy[31:0];
    if (d_side.neg) begin
      vel = ~av + 32'd1;
    end else begin
      vel = av[31] ? 32'h7FFF_FFFF : av;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (prof.deg) begin
        pos_o <= prof.plen;
        spd_o <= '0;
        axp_o <= d_side.a_end;
        vel_o <= '0;
        phase_o <= tps_pkg::PH_DEGEN;
        done_o <= 1'b1;
      end else begin
        pos_o <= d_side.pos;
        spd_o <= d_side.spd;
        axp_o <= ax_sat;
        vel_o <= vel;
        phase_o <= d_side.phase;
        done_o <= d_side.done;
      end
    end
  end

  assign m_tdata = {7'b0, done_o, phase_o, vel_o, axp_o, spd_o, pos_o};

  `TPS_ASSERT_IMP(a_degen_quiet, m_tvalid && phase_o == tps_pkg::PH_DEGEN,
                  spd_o == '0 && vel_o == '0 && done_o)
endmodule
